[design/bcba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap allocator package
// Shared widths, codes, defaults and the result record of the allocator core.
// ----------------------------------------------------------------------------
package bcba_pkg;

   localparam int MAX_BLOCKS_DEF    = 1024;
   localparam int MAP_WORD_BITS_DEF = 32;

   localparam int MODE_W     = 2;
   localparam int INDEX_W    = 10;
   localparam int LEN_W      = 11;
   localparam int LIMIT_W    = 11;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   // reciprocal shift for splitting a block index into word and bit
   localparam int DIV_SHIFT = INDEX_W + 7;

   localparam logic [LIMIT_W-1:0] BLOCKS_RESET = LIMIT_W'(1024);

   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_ROOM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  start;
      logic                taken;
   } res_type;

endpackage
`default_nettype wire

[design/bcba_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bcba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[design/bitmap_contiguous_block_allocator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Allocate: scans map words until a free run is found, then marks the words below
//   the run's last word, before the result register; one map word per cycle.
// Free and query: index split, map read, update, result.
// One item in flight; the next item is taken while a result waits on rsp.
// Reset clears the map in a pass over all MAP_WORDS words with req_tready low.
// ----------------------------------------------------------------------------
// Bitmap first-fit contiguous block allocator
// Keeps one bit per block in a word-wide RAM; scans for the first free run,
// marks it, frees or queries single blocks.
// ----------------------------------------------------------------------------
module bitmap_contiguous_block_allocator_core
   import bcba_pkg::*;
#(
   parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
   parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // block_index, run_length, zero fill
   input  wire logic [MODE_W-1:0]     req_tuser,   // mode
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,   // run_start, is_taken, zero fill
   output logic      [STATUS_W-1:0]   rsp_tuser,   // status
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [LIMIT_W-1:0]    csr_data     // blocks_in_use
);

   localparam int MAP_WORDS  = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int ADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W      = $clog2(MAP_WORD_BITS);
   localparam int CNT_W      = $clog2(MAP_WORD_BITS + 1);
   localparam int RUN_W      = LEN_W + 1;
   localparam int BASE_RAW_W = $clog2(MAX_BLOCKS + MAP_WORD_BITS + 1);
   localparam int BASE_W     = (BASE_RAW_W > LEN_W) ? BASE_RAW_W : LEN_W;
   localparam int RECIP      = ((1 << DIV_SHIFT) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LOCATE = 3'd2;
   localparam logic [2:0] S_APPLY  = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_MARK   = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   function automatic logic [MAP_WORD_BITS-1:0] low_ones(input logic [CNT_W-1:0] n);
      logic [MAP_WORD_BITS:0] wide;
      wide = ((MAP_WORD_BITS+1)'(1) << n) - (MAP_WORD_BITS+1)'(1);
      return wide[MAP_WORD_BITS-1:0];
   endfunction

   logic [2:0]               state_ff, state_in;
   logic [ADDR_W-1:0]        ptr_ff, ptr_in;
   logic [BASE_W-1:0]        base_ff, base_in;
   logic [RUN_W-1:0]         carry_ff, carry_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [LEN_W-1:0]         rem_ff, rem_in;
   logic [INDEX_W-1:0]       idx_ff, idx_in;
   logic [BIT_W-1:0]         bit_ff, bit_in;
   logic [MODE_W-1:0]        mode_ff, mode_in;
   res_type                  res_ff, res_in;
   res_type                  out_ff, out_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0]       blocks_ff, blocks_in;
   logic [LIMIT_W-1:0]       limit;

   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [MAP_WORD_BITS-1:0] wr_data;
   logic [ADDR_W-1:0]        rd_addr;
   logic [MAP_WORD_BITS-1:0] rd_data;

   logic [INDEX_W-1:0]       req_idx;
   logic [LEN_W-1:0]         req_len;
   logic [ADDR_W-1:0]        idx_word;

   logic [MAP_WORD_BITS-1:0] free_v;
   logic [RUN_W-1:0]         run_v [MAP_WORD_BITS];
   logic [MAP_WORD_BITS-1:0] hit_v;
   logic                     any_blk;
   logic [BIT_W-1:0]         last_blk;
   logic                     hit_any;
   logic [BIT_W-1:0]         hit_pos;
   logic [CNT_W-1:0]         pos1;
   logic [CNT_W-1:0]         hit_cnt;
   logic [MAP_WORD_BITS-1:0] hit_mask;
   logic [CNT_W-1:0]         mark_cnt;
   logic [MAP_WORD_BITS-1:0] mark_mask;
   logic                     out_free;

   bcba_ram #(
      .WIDTH  (MAP_WORD_BITS),
      .DEPTH  (MAP_WORDS),
      .ADDR_W (ADDR_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_idx  = req_tdata[INDEX_W-1:0];
   assign req_len  = req_tdata[INDEX_W+LEN_W-1:INDEX_W];
   assign idx_word = ADDR_W'((int'(req_idx) * RECIP) >> DIV_SHIFT);

   assign limit = (int'(blocks_ff) > MAX_BLOCKS) ? LIMIT_W'(MAX_BLOCKS) : blocks_ff;

   // run of free blocks ending at each bit of the word in hand
   always_comb begin
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         free_v[j] = !rd_data[j] && ((base_ff + BASE_W'(j)) < BASE_W'(limit));
      end
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         any_blk  = 1'b0;
         last_blk = '0;
         for (int k = 0; k <= j; k++) begin
            if (!free_v[k]) begin
               any_blk  = 1'b1;
               last_blk = BIT_W'(k);
            end
         end
         run_v[j] = any_blk ? RUN_W'(j - int'(last_blk)) : carry_ff + RUN_W'(j + 1);
         hit_v[j] = free_v[j] && (run_v[j] >= RUN_W'(len_ff));
      end
      hit_any = 1'b0;
      hit_pos = '0;
      for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
         if (hit_v[j]) begin
            hit_any = 1'b1;
            hit_pos = BIT_W'(j);
         end
      end
   end

   always_comb begin
      pos1      = CNT_W'(hit_pos) + CNT_W'(1);
      hit_cnt   = (LEN_W'(pos1) <= len_ff) ? pos1 : CNT_W'(len_ff);
      hit_mask  = low_ones(hit_cnt) << (pos1 - hit_cnt);
      mark_cnt  = (rem_ff >= LEN_W'(MAP_WORD_BITS)) ? CNT_W'(MAP_WORD_BITS) : CNT_W'(rem_ff);
      mark_mask = low_ones(mark_cnt) << (CNT_W'(MAP_WORD_BITS) - mark_cnt);
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      base_in      = base_ff;
      carry_in     = carry_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      bit_in       = bit_ff;
      mode_in      = mode_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = '0;
      rd_addr      = ptr_ff;
      req_tready   = (state_ff == S_IDLE);
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      blocks_in    = csr_valid ? csr_data : blocks_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (ptr_ff == ADDR_W'(MAP_WORDS - 1)) begin
               ptr_in   = '0;
               state_in = S_IDLE;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            rd_addr = '0;
            if (req_tvalid) begin
               mode_in      = req_tuser;
               idx_in       = req_idx;
               len_in       = req_len;
               base_in      = '0;
               carry_in     = '0;
               ptr_in       = '0;
               res_in       = '0;
               res_in.status = STATUS_RANGE;
               state_in     = S_FINISH;
               priority if (req_tuser == MODE_ALLOC && req_len != '0 && req_len <= limit) begin
                  state_in = S_SCAN;
               end else if ((req_tuser == MODE_FREE || req_tuser == MODE_QUERY)
                            && LIMIT_W'(req_idx) < limit) begin
                  ptr_in   = idx_word;
                  state_in = S_LOCATE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_LOCATE: begin
            bit_in   = BIT_W'(int'(idx_ff) - int'(ptr_ff) * MAP_WORD_BITS);
            state_in = S_APPLY;
         end
         S_APPLY: begin
            res_in.status = STATUS_OK;
            if (mode_ff == MODE_QUERY) begin
               res_in.taken = rd_data[bit_ff];
            end else begin
               wr_en   = 1'b1;
               wr_data = rd_data & ~(MAP_WORD_BITS'(1) << bit_ff);
            end
            state_in = S_FINISH;
         end
         S_SCAN: begin
            if (hit_any) begin
               wr_en         = 1'b1;
               wr_data       = rd_data | hit_mask;
               res_in.status = STATUS_OK;
               res_in.start  = INDEX_W'(base_ff + BASE_W'(pos1) - BASE_W'(len_ff));
               rem_in        = len_ff - LEN_W'(hit_cnt);
               rd_addr       = ptr_ff - ADDR_W'(1);
               ptr_in        = ptr_ff - ADDR_W'(1);
               state_in      = (len_ff == LEN_W'(hit_cnt)) ? S_FINISH : S_MARK;
            end else if ((base_ff + BASE_W'(MAP_WORD_BITS)) >= BASE_W'(limit)) begin
               res_in.status = STATUS_NO_ROOM;
               state_in      = S_FINISH;
            end else begin
               rd_addr  = ptr_ff + ADDR_W'(1);
               ptr_in   = ptr_ff + ADDR_W'(1);
               base_in  = base_ff + BASE_W'(MAP_WORD_BITS);
               carry_in = run_v[MAP_WORD_BITS-1];
            end
         end
         S_MARK: begin
            wr_en    = 1'b1;
            wr_data  = rd_data | mark_mask;
            rem_in   = rem_ff - LEN_W'(mark_cnt);
            rd_addr  = ptr_ff - ADDR_W'(1);
            ptr_in   = ptr_ff - ADDR_W'(1);
            if (rem_ff == LEN_W'(mark_cnt)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         blocks_ff    <= BLOCKS_RESET;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         blocks_ff    <= blocks_in;
      end
      base_ff  <= base_in;
      carry_ff <= carry_in;
      len_ff   <= len_in;
      rem_ff   <= rem_in;
      idx_ff   <= idx_in;
      bit_ff   <= bit_in;
      mode_ff  <= mode_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {{(RSP_DATA_W - INDEX_W - 1){1'b0}}, out_ff.taken, out_ff.start};

endmodule
`default_nettype wire

[bench/bitmap_contiguous_block_allocator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap contiguous block allocator testbench
// Drives allocate, free and query beats through the request stream, keeps a
// private copy of the allocation map and block limit, and checks every response
// beat field by field in order. Sender and receiver idle at random, the block
// limit is rewritten between phases, and one long receiver hold fills the core.
// ----------------------------------------------------------------------------
module bitmap_contiguous_block_allocator_core_tb
   import bcba_pkg::*;
;

   localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;

   class alloc_scoreboard;
      bit [MAX_BLOCKS_DEF-1:0] block_map;
      logic [LIMIT_W-1:0]      blocks_in_use;
      res_type                 expected_results[$];
      int                      errors;

      function new();
         block_map     = '0;
         blocks_in_use = BLOCKS_RESET;
         errors        = 0;
      endfunction

      function int limit();
         return (blocks_in_use > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(blocks_in_use);
      endfunction

      function void set_blocks(logic [LIMIT_W-1:0] value);
         blocks_in_use = value;
      endfunction

      // first taken block at or after a random point below the limit, else that point
      function int find_taken(int lim);
         int s;
         int b;
         s = $urandom_range(0, lim - 1);
         for (b = s; b < lim; b++)
            if (block_map[b]) return b;
         return s;
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                                 logic [LEN_W-1:0] len);
         res_type r;
         int      lim;
         int      run;
         int      b;
         int      k;
         r        = '0;
         r.status = STATUS_RANGE;
         lim      = limit();
         case (mode)
            MODE_ALLOC: begin
               if (len != 0 && len <= lim) begin
                  r.status = STATUS_NO_ROOM;
                  run      = 0;
                  for (b = 0; b < lim; b++) begin
                     if (block_map[b]) begin
                        run = 0;
                     end else begin
                        run++;
                        if (run == len) begin
                           for (k = b + 1 - len; k <= b; k++) block_map[k] = 1'b1;
                           r.status = STATUS_OK;
                           r.start  = INDEX_W'(b + 1 - len);
                           break;
                        end
                     end
                  end
               end
            end
            MODE_FREE: begin
               if (idx < lim) begin
                  block_map[idx] = 1'b0;
                  r.status       = STATUS_OK;
               end
            end
            MODE_QUERY: begin
               if (idx < lim) begin
                  r.taken  = block_map[idx];
                  r.status = STATUS_OK;
               end
            end
            default: ;
         endcase
         expected_results.push_back(r);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [INDEX_W-1:0] start,
                                 logic taken);
         res_type e;
         if (expected_results.size() == 0) begin
            $error("response beat with nothing expected: status %0d start %0d taken %0d",
                   status, start, taken);
            errors++;
            return;
         end
         e = expected_results.pop_front();
         if (status !== e.status) begin
            $error("status expected %0d got %0d", e.status, status);
            errors++;
         end
         if (start !== e.start) begin
            $error("run_start expected %0d got %0d", e.start, start);
            errors++;
         end
         if (taken !== e.taken) begin
            $error("is_taken expected %0d got %0d", e.taken, taken);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [MODE_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [LIMIT_W-1:0]    csr_data;

   alloc_scoreboard sb;
   int              tx_idle_pct;
   int              rx_idle_pct;
   int              rx_hold;

   bitmap_contiguous_block_allocator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // block_index, run_length, zero fill
      .req_tuser  (req_tuser),    // mode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // run_start, is_taken, zero fill
      .rsp_tuser  (rsp_tuser),    // status
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)      // blocks_in_use
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: hold off while a long stall is pending, else stall at random
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_blocks(csr_data);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[INDEX_W-1:0],
                            req_tdata[INDEX_W+LEN_W-1:INDEX_W]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser, rsp_tdata[INDEX_W-1:0], rsp_tdata[INDEX_W]);
      end
   end

   // called and returning at a falling edge
   task automatic send_item(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                            logic [LEN_W-1:0] len);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {{(REQ_DATA_W - INDEX_W - LEN_W){1'b0}}, len, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_blocks(logic [LIMIT_W-1:0] value);
      drain();
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_random_item();
      int                  pick;
      int                  lim;
      logic [MODE_W-1:0]   mode;
      logic [INDEX_W-1:0]  idx;
      logic [LEN_W-1:0]    len;
      pick = $urandom_range(0, 99);
      lim  = sb.limit();
      idx  = INDEX_W'($urandom);
      len  = LEN_W'($urandom);
      if (pick < 35) begin
         mode = MODE_ALLOC;
         pick = $urandom_range(0, 99);
         if (pick < 75)      len = LEN_W'($urandom_range(1, 8));
         else if (pick < 92) len = LEN_W'($urandom_range(1, 64));
         else if (pick < 98) len = LEN_W'($urandom_range(1, 2047));
         else if (pick < 99) len = LEN_W'(lim);
         else                len = '0;
      end else if (pick < 93) begin
         mode = (pick < 75) ? MODE_FREE : MODE_QUERY;
         pick = $urandom_range(0, 99);
         if (lim > 0) begin
            if (pick < 55)      idx = INDEX_W'(sb.find_taken(lim));
            else if (pick < 90) idx = INDEX_W'($urandom_range(0, lim - 1));
         end
      end else begin
         mode = MODE_BAD;
      end
      send_item(mode, idx, len);
   endtask

   task automatic run_phase(int blocks, int tx_pct, int rx_pct, int count, int hold);
      write_blocks(LIMIT_W'(blocks));
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      if (hold > 0) rx_hold = hold;
      repeat (count) send_random_item();
   endtask

   initial begin
      sb          = new();
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = MODE_ALLOC;
      rsp_tready  = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold     = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_blocks(LIMIT_W'(1024));
      send_item(MODE_QUERY, 10'd0, 11'd0);
      send_item(MODE_ALLOC, 10'h3FF, 11'd1);
      send_item(MODE_ALLOC, 10'd0, 11'd0);
      send_item(MODE_ALLOC, 10'd0, 11'd1025);
      send_item(MODE_ALLOC, 10'd0, 11'd2047);
      send_item(MODE_QUERY, 10'd0, 11'd0);
      send_item(MODE_FREE, 10'd0, 11'd0);
      send_item(MODE_FREE, 10'd0, 11'd0);
      send_item(MODE_QUERY, 10'd1023, 11'd2047);
      send_item(MODE_BAD, 10'd5, 11'd3);
      send_item(MODE_ALLOC, 10'd0, 11'd1024);
      send_item(MODE_ALLOC, 10'd0, 11'd1);
      send_item(MODE_QUERY, 10'd1023, 11'd0);
      send_item(MODE_FREE, 10'd1023, 11'd0);
      send_item(MODE_FREE, 10'd511, 11'd0);
      send_item(MODE_ALLOC, 10'd0, 11'd2);
      send_item(MODE_ALLOC, 10'd0, 11'd1);
      send_item(MODE_ALLOC, 10'd0, 11'd1);
      write_blocks(LIMIT_W'(0));
      send_item(MODE_ALLOC, 10'd0, 11'd1);
      send_item(MODE_QUERY, 10'd0, 11'd0);
      write_blocks(LIMIT_W'(16));
      send_item(MODE_QUERY, 10'd20, 11'd0);
      send_item(MODE_FREE, 10'd15, 11'd0);
      send_item(MODE_ALLOC, 10'd0, 11'd1);
      write_blocks(LIMIT_W'(2047));
      send_item(MODE_QUERY, 10'd1023, 11'd0);
      send_item(MODE_QUERY, 10'd20, 11'd0);

      run_phase(1024, 35, 56, 200, 0);
      run_phase(64, 35, 56, 150, 0);
      run_phase(2047, 56, 35, 200, 0);
      run_phase(1, 56, 35, 60, 0);
      run_phase(300, 0, 0, 200, 400);
      run_phase(0, 0, 0, 40, 0);
      run_phase($urandom_range(2, 1023), 0, 0, 250, 0);

      drain();
      repeat (100) @(negedge clock);
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
